FILE: design/c_style_token_scanner_defines.svh
// ----------------------------------------------------------------------------
// C-style token scanner assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef C_STYLE_TOKEN_SCANNER_DEFINES_SVH
`define C_STYLE_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication
`define CTSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctsc: same-cycle check failed");

// next-cycle implication
`define CTSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctsc: next-cycle check failed");

`endif

FILE: design/ctsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-style token scanner package
// Token types, kind codes and byte classification helpers.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  localparam int unsigned OFFSET_WIDTH = 32;
  localparam int unsigned COL_WIDTH    = 16;
  localparam int unsigned ROW_WIDTH    = 24;
  localparam int unsigned KIND_WIDTH   = 6;
  localparam int unsigned RUN_DEPTH    = 3;

  typedef logic [KIND_WIDTH-1:0] kind_t;

  localparam kind_t KIND_END     = 6'd0;
  localparam kind_t KIND_IDENT   = 6'd1;
  localparam kind_t KIND_INT     = 6'd2;
  localparam kind_t KIND_ERROR   = 6'd3;
  localparam kind_t KIND_INC     = 6'd4;
  localparam kind_t KIND_ADD_EQ  = 6'd5;
  localparam kind_t KIND_ADD     = 6'd6;
  localparam kind_t KIND_DEC     = 6'd7;
  localparam kind_t KIND_SUB_EQ  = 6'd8;
  localparam kind_t KIND_SUB     = 6'd9;
  localparam kind_t KIND_MUL_EQ  = 6'd10;
  localparam kind_t KIND_MUL     = 6'd11;
  localparam kind_t KIND_DIV_EQ  = 6'd12;
  localparam kind_t KIND_DIV     = 6'd13;
  localparam kind_t KIND_MOD_EQ  = 6'd14;
  localparam kind_t KIND_MOD     = 6'd15;
  localparam kind_t KIND_EQ_EQ   = 6'd16;
  localparam kind_t KIND_ASSIGN  = 6'd17;
  localparam kind_t KIND_NOT_EQ  = 6'd18;
  localparam kind_t KIND_NOT     = 6'd19;
  localparam kind_t KIND_SHL     = 6'd20;
  localparam kind_t KIND_LE      = 6'd21;
  localparam kind_t KIND_LT      = 6'd22;
  localparam kind_t KIND_USHR    = 6'd23;
  localparam kind_t KIND_SHR     = 6'd24;
  localparam kind_t KIND_GE      = 6'd25;
  localparam kind_t KIND_GT      = 6'd26;
  localparam kind_t KIND_LAND    = 6'd27;
  localparam kind_t KIND_AND     = 6'd28;
  localparam kind_t KIND_LOR     = 6'd29;
  localparam kind_t KIND_OR      = 6'd30;
  localparam kind_t KIND_XOR     = 6'd31;
  localparam kind_t KIND_TILDE   = 6'd32;
  localparam kind_t KIND_DOT     = 6'd33;
  localparam kind_t KIND_COMMA   = 6'd34;
  localparam kind_t KIND_LPAREN  = 6'd35;
  localparam kind_t KIND_RPAREN  = 6'd36;
  localparam kind_t KIND_LBRACK  = 6'd37;
  localparam kind_t KIND_RBRACK  = 6'd38;
  localparam kind_t KIND_LBRACE  = 6'd39;
  localparam kind_t KIND_RBRACE  = 6'd40;
  localparam kind_t KIND_COLON   = 6'd41;
  localparam kind_t KIND_QUEST   = 6'd42;
  localparam kind_t KIND_NONE    = 6'd0;

  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_UNDER = 8'h5F;
  localparam logic [7:0] CHR_GT    = 8'h3E;
  localparam logic [7:0] CHR_EQ    = 8'h3D;

  typedef struct packed {
    kind_t                   kind;
    logic [ROW_WIDTH-1:0]    row;
    logic [COL_WIDTH-1:0]    col;
    logic [COL_WIDTH-1:0]    len;
    logic [OFFSET_WIDTH-1:0] offset;
  } token_t;

  typedef struct packed {
    logic [1:0]                count;
    token_t [RUN_DEPTH-1:0]    tok;
  } run_t;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_word_begin(input logic [7:0] c);
    is_word_begin = is_alpha(c) || (c == CHR_UNDER);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    is_word = is_word_begin(c) || is_digit(c);
  endfunction

  function automatic logic may_pair(input logic [7:0] c);
    may_pair = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
               (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == "&") ||
               (c == "|");
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    case (c)
      "+":     single_kind = KIND_ADD;
      "-":     single_kind = KIND_SUB;
      "*":     single_kind = KIND_MUL;
      "/":     single_kind = KIND_DIV;
      "%":     single_kind = KIND_MOD;
      "=":     single_kind = KIND_ASSIGN;
      "!":     single_kind = KIND_NOT;
      "<":     single_kind = KIND_LT;
      ">":     single_kind = KIND_GT;
      "&":     single_kind = KIND_AND;
      "|":     single_kind = KIND_OR;
      "^":     single_kind = KIND_XOR;
      "~":     single_kind = KIND_TILDE;
      ".":     single_kind = KIND_DOT;
      ",":     single_kind = KIND_COMMA;
      "(":     single_kind = KIND_LPAREN;
      ")":     single_kind = KIND_RPAREN;
      "[":     single_kind = KIND_LBRACK;
      "]":     single_kind = KIND_RBRACK;
      "{":     single_kind = KIND_LBRACE;
      "}":     single_kind = KIND_RBRACE;
      ":":     single_kind = KIND_COLON;
      "?":     single_kind = KIND_QUEST;
      default: single_kind = KIND_NONE;
    endcase
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
    pair_kind = KIND_NONE;
    if (a == "+" && b == "+") pair_kind = KIND_INC;
    if (a == "+" && b == "=") pair_kind = KIND_ADD_EQ;
    if (a == "-" && b == "-") pair_kind = KIND_DEC;
    if (a == "-" && b == "=") pair_kind = KIND_SUB_EQ;
    if (a == "*" && b == "=") pair_kind = KIND_MUL_EQ;
    if (a == "/" && b == "=") pair_kind = KIND_DIV_EQ;
    if (a == "%" && b == "=") pair_kind = KIND_MOD_EQ;
    if (a == "=" && b == "=") pair_kind = KIND_EQ_EQ;
    if (a == "!" && b == "=") pair_kind = KIND_NOT_EQ;
    if (a == "<" && b == "<") pair_kind = KIND_SHL;
    if (a == "<" && b == "=") pair_kind = KIND_LE;
    if (a == ">" && b == "=") pair_kind = KIND_GE;
    if (a == "&" && b == "&") pair_kind = KIND_LAND;
    if (a == "|" && b == "|") pair_kind = KIND_LOR;
  endfunction

endpackage

FILE: design/ctsc_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-style token scanner core
// Holds the scan state and counters, and turns one byte into its token run.
// ----------------------------------------------------------------------------
module ctsc_scan_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctsc_pkg::ROW_WIDTH-1:0] cfg_first_row_i,
  input  logic                          step_i,
  input  logic [7:0]                    text_byte_i,
  input  logic                          end_of_text_i,
  output ctsc_pkg::run_t                run_o
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_INT   = 2'd2;
  localparam logic [1:0] MODE_OP    = 2'd3;

  localparam logic [ctsc_pkg::COL_WIDTH-1:0] COL_MAX = '1;
  localparam logic [ctsc_pkg::ROW_WIDTH-1:0] ROW_RESET =
    ctsc_pkg::ROW_WIDTH'(1);

  logic [1:0]                             mode_q, mode_d;
  logic [7:0]                             pend_q, pend_d;
  logic                                   dbl_q, dbl_d;
  logic [ctsc_pkg::OFFSET_WIDTH-1:0]      start_off_q, start_off_d;
  logic [ctsc_pkg::COL_WIDTH-1:0]         start_col_q, start_col_d;
  logic [ctsc_pkg::COL_WIDTH-1:0]         len_q, len_d;
  logic [ctsc_pkg::OFFSET_WIDTH-1:0]      off_q, off_d;
  logic [ctsc_pkg::COL_WIDTH-1:0]         col_q, col_d;
  logic [ctsc_pkg::ROW_WIDTH-1:0]         row_q, row_d;
  logic [ctsc_pkg::ROW_WIDTH-1:0]         first_row_q;
  logic                                   at_start_q, at_start_d;

  logic                                   taken;
  logic                                   cont;
  ctsc_pkg::kind_t                        pk;
  logic [3:0]                             cand_v;
  ctsc_pkg::token_t [3:0]                 cand;
  logic [1:0]                             n;
  ctsc_pkg::run_t                         run;

  always_comb begin
    mode_d      = mode_q;
    pend_d      = pend_q;
    dbl_d       = dbl_q;
    start_off_d = start_off_q;
    start_col_d = start_col_q;
    len_d       = len_q;
    off_d       = off_q;
    col_d       = col_q;
    row_d       = row_q;
    at_start_d  = 1'b0;
    taken       = 1'b0;
    cont        = 1'b0;
    pk          = ctsc_pkg::KIND_NONE;
    cand_v      = '0;
    cand        = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i].row    = row_q;
      cand[i].col    = start_col_q;
      cand[i].offset = start_off_q;
    end

    // offer the byte to the open token
    unique case (mode_q)
      MODE_IDENT, MODE_INT: begin
        cont = (mode_q == MODE_IDENT) ? ctsc_pkg::is_word(text_byte_i)
                                      : ctsc_pkg::is_digit(text_byte_i);
        if (cont) begin
          taken = 1'b1;
          if (len_q != COL_MAX) len_d = len_q + 1'b1;
        end else begin
          cand_v[0]    = 1'b1;
          cand[0].kind = (mode_q == MODE_IDENT) ? ctsc_pkg::KIND_IDENT
                                                : ctsc_pkg::KIND_INT;
          cand[0].len  = len_q;
          mode_d       = MODE_IDLE;
        end
      end
      MODE_OP: begin
        pk = ctsc_pkg::pair_kind(pend_q, text_byte_i);
        if (dbl_q) begin
          mode_d    = MODE_IDLE;
          pend_d    = '0;
          dbl_d     = 1'b0;
          cand_v[0] = 1'b1;
          if (text_byte_i == ctsc_pkg::CHR_GT) begin
            taken        = 1'b1;
            cand[0].kind = ctsc_pkg::KIND_USHR;
            cand[0].len  = ctsc_pkg::COL_WIDTH'(3);
          end else begin
            cand[0].kind = ctsc_pkg::KIND_SHR;
            cand[0].len  = ctsc_pkg::COL_WIDTH'(2);
          end
        end else if (pend_q == ctsc_pkg::CHR_GT && text_byte_i == ctsc_pkg::CHR_GT) begin
          taken = 1'b1;
          dbl_d = 1'b1;
        end else begin
          mode_d    = MODE_IDLE;
          pend_d    = '0;
          cand_v[0] = 1'b1;
          if (pk != ctsc_pkg::KIND_NONE) begin
            taken        = 1'b1;
            cand[0].kind = pk;
            cand[0].len  = ctsc_pkg::COL_WIDTH'(2);
          end else begin
            cand[0].kind = ctsc_pkg::single_kind(pend_q);
            cand[0].len  = ctsc_pkg::COL_WIDTH'(1);
          end
        end
      end
      default: begin
      end
    endcase

    // open a new token
    if (!taken && !ctsc_pkg::is_space(text_byte_i)) begin
      start_off_d = off_q;
      start_col_d = col_q;
      len_d       = ctsc_pkg::COL_WIDTH'(1);
      if (ctsc_pkg::is_word_begin(text_byte_i)) begin
        mode_d = MODE_IDENT;
      end else if (ctsc_pkg::is_digit(text_byte_i)) begin
        mode_d = MODE_INT;
      end else if (ctsc_pkg::may_pair(text_byte_i)) begin
        mode_d = MODE_OP;
        pend_d = text_byte_i;
      end else begin
        cand_v[1]      = 1'b1;
        cand[1].kind   = (ctsc_pkg::single_kind(text_byte_i) != ctsc_pkg::KIND_NONE)
                         ? ctsc_pkg::single_kind(text_byte_i) : ctsc_pkg::KIND_ERROR;
        cand[1].col    = col_q;
        cand[1].offset = off_q;
        cand[1].len    = ctsc_pkg::COL_WIDTH'(1);
      end
    end

    // advance position
    off_d = off_q + 1'b1;
    if (text_byte_i == ctsc_pkg::CHR_NL) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else if (col_q != COL_MAX) begin
      col_d = col_q + 1'b1;
    end

    // flush and close on the final byte
    if (end_of_text_i) begin
      cand[2].row    = row_d;
      cand[2].col    = start_col_d;
      cand[2].offset = start_off_d;
      unique case (mode_d)
        MODE_IDENT, MODE_INT: begin
          cand_v[2]    = 1'b1;
          cand[2].kind = (mode_d == MODE_IDENT) ? ctsc_pkg::KIND_IDENT
                                                : ctsc_pkg::KIND_INT;
          cand[2].len  = len_d;
        end
        MODE_OP: begin
          cand_v[2] = 1'b1;
          if (dbl_d) begin
            cand[2].kind = ctsc_pkg::KIND_SHR;
            cand[2].len  = ctsc_pkg::COL_WIDTH'(2);
          end else begin
            cand[2].kind = ctsc_pkg::single_kind(pend_d);
            cand[2].len  = ctsc_pkg::COL_WIDTH'(1);
          end
        end
        default: begin
        end
      endcase
      cand_v[3]   = 1'b1;
      cand[3]     = '0;
      mode_d      = MODE_IDLE;
      pend_d      = '0;
      dbl_d       = 1'b0;
      start_off_d = '0;
      start_col_d = '0;
      len_d       = '0;
      off_d       = '0;
      col_d       = '0;
      row_d       = first_row_q;
      at_start_d  = 1'b1;
    end
  end

  // pack the valid candidates in order
  always_comb begin
    n   = '0;
    run = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n != 2'd3) begin
        run.tok[n] = cand[i];
        n          = n + 1'b1;
      end
    end
    run.count = n;
  end

  assign run_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pend_q      <= '0;
      dbl_q       <= 1'b0;
      start_off_q <= '0;
      start_col_q <= '0;
      len_q       <= '0;
      off_q       <= '0;
      col_q       <= '0;
      row_q       <= ROW_RESET;
      first_row_q <= ROW_RESET;
      at_start_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        first_row_q <= cfg_first_row_i;
        if (at_start_q) row_q <= cfg_first_row_i;
      end
      if (step_i) begin
        mode_q      <= mode_d;
        pend_q      <= pend_d;
        dbl_q       <= dbl_d;
        start_off_q <= start_off_d;
        start_col_q <= start_col_d;
        len_q       <= len_d;
        off_q       <= off_d;
        col_q       <= col_d;
        row_q       <= row_d;
        at_start_q  <= at_start_d;
      end
    end
  end

endmodule

FILE: design/ctsc_token_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-style token scanner result buffer
// Holds the token run of one byte and hands it out one beat at a time.
// ----------------------------------------------------------------------------
module ctsc_token_buf (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  ctsc_pkg::run_t                    run_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ctsc_pkg::KIND_WIDTH-1:0]   token_kind_o,
  output logic [ctsc_pkg::ROW_WIDTH-1:0]    token_row_o,
  output logic [ctsc_pkg::COL_WIDTH-1:0]    token_col_o,
  output logic [ctsc_pkg::COL_WIDTH-1:0]    token_len_o,
  output logic [ctsc_pkg::OFFSET_WIDTH-1:0] token_offset_o,
  output logic                              last_of_run_o
);

  ctsc_pkg::token_t [ctsc_pkg::RUN_DEPTH-1:0] tok_q;
  logic [1:0]                                  cnt_q;
  logic [1:0]                                  rd_q, rd_d;
  logic                                        fire;
  ctsc_pkg::token_t                            cur;

  assign out_valid_o = (rd_q != cnt_q);
  assign fire        = out_valid_o && !out_stall_i;
  assign rd_d        = rd_q + 1'b1;
  assign free_o      = !out_valid_o || (fire && rd_d == cnt_q);
  assign cur         = tok_q[rd_q];

  assign token_kind_o   = cur.kind;
  assign token_row_o    = cur.row;
  assign token_col_o    = cur.col;
  assign token_len_o    = cur.len;
  assign token_offset_o = cur.offset;
  assign last_of_run_o  = (rd_d == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= run_i.count;
      rd_q  <= '0;
    end else if (fire) begin
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) tok_q <= run_i.tok;
  end

endmodule

FILE: design/c_style_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-style token scanner
// Flow: a byte is captured in the input register, scanned into the result buffer
// once the buffer is free, and its first token beat is then offered. Throughput:
// one byte per cycle while each byte yields at most one token and out_stall_i is low;
// a byte yielding more holds the input register until the result buffer drains it.
// Reset: asynchronous, active low; row restarts at first_row (reset value 1).
// ----------------------------------------------------------------------------
`include "c_style_token_scanner_defines.svh"

module c_style_token_scanner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctsc_pkg::ROW_WIDTH-1:0]    cfg_first_row_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        text_byte_i,
  input  logic                              end_of_text_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ctsc_pkg::KIND_WIDTH-1:0]   token_kind_o,
  output logic [ctsc_pkg::ROW_WIDTH-1:0]    token_row_o,
  output logic [ctsc_pkg::COL_WIDTH-1:0]    token_col_o,
  output logic [ctsc_pkg::COL_WIDTH-1:0]    token_len_o,
  output logic [ctsc_pkg::OFFSET_WIDTH-1:0] token_offset_o,
  output logic                              last_of_run_o
);

  logic           in_valid_q;
  logic [7:0]     byte_q;
  logic           eot_q;
  logic           buf_free;
  logic           step;
  logic           in_fire;
  ctsc_pkg::run_t run;
  logic           end_beat;
  logic           end_blank;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q && buf_free;
  assign in_stall_o  = in_valid_q && !step;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  ctsc_scan_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_first_row_i (cfg_first_row_i),
    .step_i          (step),
    .text_byte_i     (byte_q),
    .end_of_text_i   (eot_q),
    .run_o           (run)
  );

  ctsc_token_buf u_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (step),
    .run_i          (run),
    .free_o         (buf_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_row_o    (token_row_o),
    .token_col_o    (token_col_o),
    .token_len_o    (token_len_o),
    .token_offset_o (token_offset_o),
    .last_of_run_o  (last_of_run_o)
  );

  assign end_beat  = out_valid_o && (token_kind_o == ctsc_pkg::KIND_END);
  assign end_blank = (token_row_o == '0) && (token_col_o == '0) && (token_len_o == '0) &&
                     (token_offset_o == '0);

  `CTSC_ASSERT_IMPL(a_end_closes_run, end_beat, last_of_run_o)
  `CTSC_ASSERT_IMPL(a_end_is_blank, end_beat, end_blank)
  `CTSC_ASSERT_NEXT(a_final_byte_ends, step && eot_q, out_valid_o)

endmodule
